/* design/vrsp_pkg.sv */
package vrsp_pkg;

  // Field and register widths
  localparam int unsigned VelWidth     = 16;
  localparam int unsigned StepWidth    = 15;
  localparam int unsigned NumWidth     = 32;
  localparam int unsigned CmpOutWidth  = 16;
  localparam int unsigned CfgIdxWidth  = 1;
  localparam int unsigned CompareWidth = 16;

  // Divider iteration counter holds 0..NumWidth
  localparam int unsigned DivCntWidth = $clog2(NumWidth + 1);

  // Register reset values
  localparam logic [StepWidth-1:0] RampStepReset = StepWidth'(256);
  localparam logic [NumWidth-1:0]  PeriodNumReset = NumWidth'(16084954);

  // Register indexes
  localparam logic [CfgIdxWidth-1:0] RegRampStep  = CfgIdxWidth'(0);
  localparam logic [CfgIdxWidth-1:0] RegPeriodNum = CfgIdxWidth'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_WAIT
  } vrsp_state_e;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic                done;
    logic [NumWidth-1:0] quotient;
  } vrsp_div_status_t;

endpackage

/* design/vrsp_ramp.sv */
module vrsp_ramp import vrsp_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic signed [VelWidth-1:0]  target_i,
  input  logic        [StepWidth-1:0] step_i,
  output logic signed [VelWidth-1:0]  vel_o,
  output logic signed [VelWidth-1:0]  next_vel_o,
  output logic                        stopped_o
);

  logic signed [VelWidth-1:0] vel_q, vel_d;
  logic signed [VelWidth:0]   delta;
  logic        [VelWidth:0]   mag;
  logic        [VelWidth:0]   step_ext;

  // Move toward the target by at most one step, snap when close
  always_comb begin
    delta    = VelWidth'(0) + ({target_i[VelWidth-1], target_i} - {vel_q[VelWidth-1], vel_q});
    mag      = delta[VelWidth] ? (VelWidth+1)'(-delta) : delta;
    step_ext = (VelWidth+1)'(step_i);
    if (mag <= step_ext) begin
      vel_d = target_i;
    end else if (delta[VelWidth]) begin
      vel_d = vel_q - VelWidth'(step_i);
    end else begin
      vel_d = vel_q + VelWidth'(step_i);
    end
  end

  // Hold the current velocity between ticks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q <= '0;
    end else if (load_i) begin
      vel_q <= vel_d;
    end
  end

  assign vel_o      = vel_q;
  assign next_vel_o = vel_d;
  assign stopped_o  = vel_q[VelWidth-1] || (vel_q == '0);

endmodule

/* design/vrsp_div.sv */
module vrsp_div import vrsp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [NumWidth-1:0]    numerator_i,
  input  logic [VelWidth-1:0]    divisor_i,
  output vrsp_div_status_t       status_o
);

  // Restoring divider: one quotient bit per cycle, numerator shifts out
  // at the top while quotient bits shift in at the bottom.
  logic [NumWidth-1:0]    num_q, num_d;
  logic [VelWidth-1:0]    rem_q, rem_d;
  logic [VelWidth-1:0]    div_q;
  logic [DivCntWidth-1:0] cnt_q, cnt_d;
  logic [VelWidth:0]      trial;
  logic                   ge;
  logic                   busy;

  assign busy = (cnt_q != '0);

  always_comb begin
    trial = {rem_q, num_q[NumWidth-1]};
    ge    = trial >= {1'b0, div_q};
    num_d = num_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (busy) begin
      num_d = {num_q[NumWidth-2:0], ge};
      rem_d = ge ? VelWidth'(trial - {1'b0, div_q}) : trial[VelWidth-1:0];
      cnt_d = cnt_q - DivCntWidth'(1);
    end
  end

  // Count down the iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= DivCntWidth'(NumWidth);
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Shift the datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= numerator_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign status_o.done     = (cnt_q == DivCntWidth'(1));
  assign status_o.quotient = num_d;

endmodule

/* design/velocity_ramp_step_period.sv */
// Velocity ramp with step-period output. Each input word is one ramp tick
// carrying a target velocity (signed Q7.8). The held velocity moves toward
// it by at most ramp_step (register 0) and snaps to the target when the gap
// is within one step. The new velocity is returned with a timer compare
// value, period_numerator (register 1) divided by the velocity, truncated
// and saturated at 2^COMPARE_WIDTH-1; zero or negative velocity gives the
// maximum and raises stopped. Each result word is loaded once the bit-serial
// 32-by-16 divider, producing one quotient bit per cycle, has finished. Ticks
// are processed one at a time: the next tick is taken at the earliest in the
// cycle after the result is loaded. A finished result may wait in the output
// register while the next tick is accepted.
module velocity_ramp_step_period import vrsp_pkg::*; #(
  parameter int unsigned COMPARE_WIDTH = CompareWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic        [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic        [NumWidth-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VelWidth-1:0]    target_velocity_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [VelWidth-1:0]    applied_velocity_o,
  output logic        [CmpOutWidth-1:0] compare_value_o,
  output logic                          stopped_o
);

  localparam logic [NumWidth-1:0] CmpMax = NumWidth'((64'd1 << COMPARE_WIDTH) - 64'd1);

  vrsp_state_e state_q, state_d;

  logic [StepWidth-1:0] ramp_step_q;
  logic [NumWidth-1:0]  period_num_q;

  logic                        accept;
  logic                        result_ready;
  logic                        load_out;
  logic signed [VelWidth-1:0]  vel;
  logic signed [VelWidth-1:0]  next_vel;
  logic                        stopped;
  vrsp_div_status_t            div_status;
  logic [NumWidth-1:0]         cmp_sat;

  logic                        out_valid_q, out_valid_d;
  logic signed [VelWidth-1:0]  out_vel_q;
  logic [CmpOutWidth-1:0]      out_cmp_q;
  logic                        out_stop_q;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_step_q  <= RampStepReset;
      period_num_q <= PeriodNumReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRampStep:  ramp_step_q  <= cfg_data_i[StepWidth-1:0];
        RegPeriodNum: period_num_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  vrsp_ramp u_ramp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .target_i   (target_velocity_i),
    .step_i     (ramp_step_q),
    .vel_o      (vel),
    .next_vel_o (next_vel),
    .stopped_o  (stopped)
  );

  vrsp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .numerator_i (period_num_q),
    .divisor_i   (next_vel),
    .status_o    (div_status)
  );

  // Saturate the quotient; non-positive velocity forces the maximum
  assign cmp_sat = (stopped || (div_status.quotient > CmpMax)) ? CmpMax
                                                               : div_status.quotient;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    result_ready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        result_ready = div_status.done;
        if (div_status.done) state_d = load_out ? ST_IDLE : ST_WAIT;
      end
      ST_WAIT: begin
        result_ready = 1'b1;
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign load_out    = result_ready && (!out_valid_q || !out_stall_i);
  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_vel_q  <= vel;
      out_cmp_q  <= cmp_sat[CmpOutWidth-1:0];
      out_stop_q <= stopped;
    end
  end

  assign in_stall_o         = (state_q != ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign applied_velocity_o = out_vel_q;
  assign compare_value_o    = out_cmp_q;
  assign stopped_o          = out_stop_q;

endmodule

/* design/vrsp_checker.sv */
module vrsp_checker import vrsp_pkg::*; #(
  parameter int unsigned COMPARE_WIDTH = CompareWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic signed [VelWidth-1:0]    applied_velocity_o,
  input  logic        [CmpOutWidth-1:0] compare_value_o,
  input  logic                          stopped_o
);

  localparam logic [CmpOutWidth-1:0] CmpMaxOut =
    CmpOutWidth'((64'd1 << COMPARE_WIDTH) - 64'd1);

  // A stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(applied_velocity_o) && $stable(compare_value_o)
      && $stable(stopped_o))
    else $error("stalled result word changed");

  // Stopped flag matches the sign of the velocity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (stopped_o == (applied_velocity_o <= 0)))
    else $error("stopped flag disagrees with applied velocity");

  // A stopped motor gets the maximum compare value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stopped_o |-> (compare_value_o == CmpMaxOut))
    else $error("stopped word without maximum compare value");

  // An accepted word keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a word");

endmodule

bind velocity_ramp_step_period vrsp_checker #(
  .COMPARE_WIDTH (COMPARE_WIDTH)
) u_vrsp_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .applied_velocity_o (applied_velocity_o),
  .compare_value_o    (compare_value_o),
  .stopped_o          (stopped_o)
);
